>>> rtl/tkvht_pkg.sv
// shared constants, types and hash helper for the key-value table with expiry
// no dependencies
`default_nettype none
package tkvht_pkg;
    localparam int BUCKETS   = 1024;
    localparam int WAYS      = 4;
    localparam int KEY_BYTES = 8;
    localparam int SLOTS     = BUCKETS * WAYS;
    localparam int BKT_W     = $clog2(BUCKETS);
    localparam int CNT_W     = 13;
    localparam int KEY_W     = 64;
    localparam int VAL_W     = 64;
    localparam int EXP_W     = 33;
    localparam int LIFE_W    = 31;
    localparam int NOW_W     = 32;
    localparam int IN_W      = 200;
    localparam int OUT_W     = 80;
    localparam logic [63:0] HASH_SEED = 64'd5381;

    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_GET   = 2'd1;
    localparam logic [1:0] ACT_DEL   = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic load;
        logic rd;
        logic exec;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic in_clear;
        logic clr_last;
        logic out_busy;
    } t_sts;

    // trims the key at its first zero byte
    function automatic logic [KEY_W-1:0] key_trim(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] norm;
        logic             live;
        norm = '0;
        live = 1'b1;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (raw[8*i +: 8] == 8'd0) live = 1'b0;
            if (live) norm[8*i +: 8] = raw[8*i +: 8];
        end
        return norm;
    endfunction

    // djb2 hash kept to the bucket bits only, since the low bits never see the high ones
    function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] norm);
        logic [BKT_W-1:0] h;
        h = HASH_SEED[BKT_W-1:0];
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (norm[8*i +: 8] != 8'd0)
                h = BKT_W'(({h, 5'd0}) + {5'd0, h} + (BKT_W+5)'(norm[8*i +: 8]));
            else
                h = h;
        end
        return h;
    endfunction
endpackage
`default_nettype wire

>>> rtl/tkvht_ctrl.sv
// sequencing state machine for the key-value table
// depends on tkvht_pkg
`default_nettype none
module tkvht_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  tkvht_pkg::t_sts  i_sts,
    output tkvht_pkg::t_cmd  o_cmd
);
    import tkvht_pkg::*;

    localparam logic [2:0] S_RST_CLR = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_RD      = 3'd2;
    localparam logic [2:0] S_EXEC    = 3'd3;
    localparam logic [2:0] S_CLR     = 3'd4;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_RST_CLR;
        else          r_state <= n_state;
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_RST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_clear ? S_CLR : S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                if (!i_sts.out_busy) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_EXEC;
            end
            default: n_state = S_RST_CLR;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/tkvht_dp.sv
// bucket memories, way compare, entry count and result register
// depends on tkvht_pkg
`default_nettype none
module tkvht_dp (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  [tkvht_pkg::IN_W-1:0]  i_in_data,
    input  tkvht_pkg::t_cmd             i_cmd,
    output tkvht_pkg::t_sts             o_sts,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic [tkvht_pkg::OUT_W-1:0] o_out_data
);
    import tkvht_pkg::*;

    logic [WAYS-1:0]       vld_mem [BUCKETS];
    logic [WAYS*KEY_W-1:0] key_mem [BUCKETS];
    logic [WAYS*VAL_W-1:0] val_mem [BUCKETS];
    logic [WAYS*EXP_W-1:0] exp_mem [BUCKETS];

    logic [1:0]        r_act;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_val;
    logic [EXP_W-1:0]  r_exp_new;
    logic [NOW_W-1:0]  r_now;
    logic [BKT_W-1:0]  r_bkt;
    logic [BKT_W-1:0]  r_clr_addr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic [WAYS-1:0]       r_rd_vld;
    logic [WAYS*KEY_W-1:0] r_rd_key;
    logic [WAYS*VAL_W-1:0] r_rd_val;
    logic [WAYS*EXP_W-1:0] r_rd_exp;

    logic [KEY_W-1:0]  in_norm;
    logic [WAYS-1:0]   hit_oh, free_oh, n_vld;
    logic              any_hit, any_free, wr_vld, wr_data, expired;
    logic [VAL_W-1:0]  hit_val;
    logic [EXP_W-1:0]  hit_exp;
    logic [WAYS*KEY_W-1:0] n_key;
    logic [WAYS*VAL_W-1:0] n_val;
    logic [WAYS*EXP_W-1:0] n_exp;
    logic [1:0]        n_status;
    logic [VAL_W-1:0]  n_rv;

    assign in_norm        = key_trim(i_in_data[65:2]);
    assign o_sts.in_clear = (i_in_data[1:0] == ACT_CLEAR);
    assign o_sts.clr_last = &r_clr_addr;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    // request capture and bucket hash
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act     <= i_in_data[1:0];
            r_key     <= in_norm;
            r_val     <= i_in_data[129:66];
            r_exp_new <= EXP_W'(i_in_data[192:161]) + EXP_W'(i_in_data[160:130]);
            r_now     <= i_in_data[192:161];
            r_bkt     <= bucket_of(in_norm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_vld <= vld_mem[r_bkt];
            r_rd_key <= key_mem[r_bkt];
            r_rd_val <= val_mem[r_bkt];
            r_rd_exp <= exp_mem[r_bkt];
        end
    end

    // first matching way and first free way
    always_comb begin
        hit_oh   = '0;
        free_oh  = '0;
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_val  = '0;
        hit_exp  = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (r_rd_vld[w]) begin
                if (!any_hit && r_rd_key[w*KEY_W +: KEY_W] == r_key) begin
                    hit_oh[w] = 1'b1;
                    any_hit   = 1'b1;
                    hit_val   = r_rd_val[w*VAL_W +: VAL_W];
                    hit_exp   = r_rd_exp[w*EXP_W +: EXP_W];
                end
            end else if (!any_free) begin
                free_oh[w] = 1'b1;
                any_free   = 1'b1;
            end
        end
    end

    assign expired = EXP_W'(r_now) > hit_exp;

    always_comb begin
        n_vld    = r_rd_vld;
        n_key    = r_rd_key;
        n_val    = r_rd_val;
        n_exp    = r_rd_exp;
        n_count  = r_count;
        n_status = ST_MISS;
        n_rv     = '0;
        wr_vld   = 1'b0;
        wr_data  = 1'b0;
        case (r_act)
            ACT_CLEAR: begin
                n_count  = '0;
                n_status = ST_OK;
            end
            ACT_SET: begin
                if (any_hit || any_free) begin
                    n_status = ST_OK;
                    wr_vld   = 1'b1;
                    wr_data  = 1'b1;
                    if (!any_hit) n_count = r_count + CNT_W'(1);
                    for (int w = 0; w < WAYS; w++) begin
                        if (any_hit ? hit_oh[w] : free_oh[w]) begin
                            n_vld[w]                = 1'b1;
                            n_key[w*KEY_W +: KEY_W] = r_key;
                            n_val[w*VAL_W +: VAL_W] = r_val;
                            n_exp[w*EXP_W +: EXP_W] = r_exp_new;
                        end
                    end
                end else begin
                    n_status = ST_FULL;
                end
            end
            default: begin
                if (any_hit) begin
                    if (r_act == ACT_GET && !expired) begin
                        n_status = ST_OK;
                        n_rv     = hit_val;
                    end else begin
                        wr_vld   = 1'b1;
                        n_vld    = r_rd_vld & ~hit_oh;
                        if (r_count != '0) n_count = r_count - CNT_W'(1);
                        n_status = (r_act == ACT_DEL) ? ST_OK : ST_MISS;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step)
            vld_mem[r_clr_addr] <= '0;
        else if (i_cmd.exec && wr_vld)
            vld_mem[r_bkt] <= n_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_data) begin
            key_mem[r_bkt] <= n_key;
            val_mem[r_bkt] <= n_val;
            exp_mem[r_bkt] <= n_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + BKT_W'(1);
            if (i_cmd.exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) r_out_data <= {1'b0, n_count, n_rv, n_status};
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("entry count beyond table size");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before taken");
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clr_step && (i_cmd.exec || i_cmd.rd || i_cmd.load)))
        else $error("clear sweep overlaps other work");
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_act == ACT_CLEAR) |=> r_count == '0)
        else $error("count not zero after clear");
endmodule
`default_nettype wire

>>> rtl/ttl_key_value_hash_table.sv
// top level of the key-value table with expiry: controller plus datapath
// depends on tkvht_pkg, tkvht_ctrl, tkvht_dp
//
// channel   dir  fields (low bit up)
// s (in)    in   action[1:0] item_key[65:2] item_value[129:66] life_seconds[160:130]
//                now_seconds[192:161], zero fill to 200
// m (out)   out  status[1:0] read_value[65:2] entry_count[78:66], zero fill to 80
//
// get, set and delete each pass through hash and capture, one bucket row read,
// then compare and write back, which waits while the output register is still full.
// clear sweeps one bucket row per cycle across all 1024 bucket rows.
// after reset the same sweep clears all 1024 bucket rows before the first request.
// a result waits in the output register; the next request is taken meanwhile.
`default_nettype none
module ttl_key_value_hash_table (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_s_tvalid,
    output logic                         o_s_tready,
    input  wire  [tkvht_pkg::IN_W-1:0]   i_s_tdata,   // action, item_key, item_value, life_seconds, now_seconds
    output logic                         o_m_tvalid,
    input  wire                          i_m_tready,
    output logic [tkvht_pkg::OUT_W-1:0]  o_m_tdata    // status, read_value, entry_count
);
    import tkvht_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tkvht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tkvht_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_s_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_data  (o_m_tdata)
    );
endmodule
`default_nettype wire

>>> tb/ttl_key_value_hash_table_test.sv
// self-checking bench for the key-value table with expiry: directed table then random requests
// depends on tkvht_pkg and ttl_key_value_hash_table
`default_nettype none
module ttl_key_value_hash_table_test;
    import tkvht_pkg::*;

    // laid out as on o_m_tdata: status in the low bits, entry_count on top
    typedef struct packed {
        logic [CNT_W-1:0]  entry_count;
        logic [VAL_W-1:0]  read_value;
        logic [1:0]        status;
    } t_answer;

    typedef struct {
        logic [1:0]        action;
        logic [KEY_W-1:0]  item_key;
        logic [VAL_W-1:0]  item_value;
        logic [LIFE_W-1:0] life_seconds;
        logic [NOW_W-1:0]  now_seconds;
        logic              typed;
        logic [1:0]        want_status;
        logic [CNT_W-1:0]  want_count;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic [IN_W-1:0]     i_s_tdata = '0;
    logic                i_m_tready = 1'b0;
    wire                 o_s_tready;
    wire                 o_m_tvalid;
    wire  [OUT_W-1:0]    o_m_tdata;

    // table mirror
    logic             mir_valid [SLOTS];
    logic [KEY_W-1:0] mir_key   [SLOTS];
    logic [VAL_W-1:0] mir_value [SLOTS];
    logic [EXP_W-1:0] mir_expiry[SLOTS];
    logic [CNT_W-1:0] mir_count;

    t_answer     answer_q[$];
    int          errors = 0;
    logic        stall_mode = 1'b0;
    t_row        rows[$];
    logic [KEY_W-1:0] key_pool[16];

    ttl_key_value_hash_table u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // action, item_key, item_value, life_seconds, now_seconds
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)    // status, read_value, entry_count
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20000000;
        $display("** ttl_key_value_hash_table: FAILED **");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // applies one request to the mirror and returns the answer
    function automatic t_answer table_step(input logic [1:0] act, input logic [KEY_W-1:0] raw,
                                           input logic [VAL_W-1:0] val,
                                           input logic [LIFE_W-1:0] life,
                                           input logic [NOW_W-1:0] now);
        t_answer          a;
        logic [KEY_W-1:0] norm;
        logic [63:0]      h;
        logic             live;
        int               base, hit, free_way, s;
        a = '0;
        a.status = ST_MISS;
        norm = '0;
        h = 64'd5381;
        live = 1'b1;
        hit = -1;
        free_way = -1;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (raw[8*i +: 8] == 8'd0) live = 1'b0;
            if (live) begin
                h = h * 64'd33 + 64'(raw[8*i +: 8]);
                norm[8*i +: 8] = raw[8*i +: 8];
            end
        end
        base = int'(h % 64'(BUCKETS)) * WAYS;
        if (act == ACT_CLEAR) begin
            foreach (mir_valid[i]) mir_valid[i] = 1'b0;
            mir_count = '0;
            a.status = ST_OK;
        end else begin
            for (int w = 0; w < WAYS; w++) begin
                if (mir_valid[base+w]) begin
                    if (hit < 0 && mir_key[base+w] == norm) hit = w;
                end else if (free_way < 0) begin
                    free_way = w;
                end
            end
            if (act == ACT_SET) begin
                s = (hit >= 0) ? hit : free_way;
                if (s < 0) begin
                    a.status = ST_FULL;
                end else begin
                    if (hit < 0) begin
                        mir_valid[base+s] = 1'b1;
                        mir_key[base+s] = norm;
                        mir_count++;
                    end
                    mir_value[base+s] = val;
                    mir_expiry[base+s] = EXP_W'(now) + EXP_W'(life);
                    a.status = ST_OK;
                end
            end else if (hit >= 0) begin
                s = base + hit;
                if (act == ACT_GET && !(EXP_W'(now) > mir_expiry[s])) begin
                    a.read_value = mir_value[s];
                    a.status = ST_OK;
                end else begin
                    mir_valid[s] = 1'b0;
                    if (mir_count > 0) mir_count--;
                    a.status = (act == ACT_DEL) ? ST_OK : ST_MISS;
                end
            end
        end
        a.entry_count = mir_count;
        return a;
    endfunction

    task automatic send_request(input t_row r);
        t_answer a;
        i_s_tdata <= {7'd0, r.now_seconds, r.life_seconds, r.item_value, r.item_key, r.action};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        a = table_step(r.action, r.item_key, r.item_value, r.life_seconds, r.now_seconds);
        if (r.typed && (a.status != r.want_status || a.entry_count != r.want_count))
            report("typed row", 64'({a.status, a.entry_count}),
                   64'({r.want_status, r.want_count}));
        answer_q.push_back(a);
    endtask

    function automatic t_row mk(input logic [1:0] act, input logic [KEY_W-1:0] k,
                                input logic [VAL_W-1:0] v, input logic [LIFE_W-1:0] l,
                                input logic [NOW_W-1:0] n);
        t_row r;
        r.action = act; r.item_key = k; r.item_value = v;
        r.life_seconds = l; r.now_seconds = n; r.typed = 1'b0;
        r.want_status = ST_OK; r.want_count = '0;
        return r;
    endfunction

    function automatic t_row mkt(input t_row r, input logic [1:0] st, input int cnt);
        r.typed = 1'b1; r.want_status = st; r.want_count = CNT_W'(cnt);
        return r;
    endfunction

    // result side: stall pattern flips between a busy and a free stretch
    always @(posedge i_clk) begin
        t_answer got, want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (($urandom % 40) == 0) stall_mode <= ~stall_mode;
            i_m_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
            if (o_m_tvalid && i_m_tready) begin
                got = t_answer'(o_m_tdata[78:0]);
                if (answer_q.size() == 0) begin
                    report("unexpected result", 64'(got.status), 64'd0);
                end else begin
                    want = answer_q.pop_front();
                    if (got.status != want.status)
                        report("status", 64'(got.status), 64'(want.status));
                    if (got.read_value != want.read_value)
                        report("read_value", got.read_value, want.read_value);
                    if (got.entry_count != want.entry_count)
                        report("entry_count", 64'(got.entry_count), 64'(want.entry_count));
                end
            end
        end
    end

    initial begin
        t_row r;
        int   burst, k;
        foreach (mir_valid[i]) mir_valid[i] = 1'b0;
        mir_count = '0;
        for (int i = 0; i < 16; i++)
            key_pool[i] = {$urandom, $urandom} & {8{8'h00 | 8'(($urandom_range(0,7) == 0) ? 0 : 8'hff)}};
        key_pool[0] = 64'h0;
        key_pool[1] = '1;
        key_pool[2] = 64'h61;
        // directed table: extremes, every action, expiry, full bucket, normalization
        rows.push_back(mkt(mk(ACT_GET, 64'h61, 0, 0, 0), ST_MISS, 0));
        rows.push_back(mkt(mk(ACT_DEL, 64'h61, 0, 0, 0), ST_MISS, 0));
        rows.push_back(mkt(mk(ACT_SET, 64'h0, '1, 0, 0), ST_OK, 1));
        rows.push_back(mk(ACT_GET, 64'hff00_0000_0000_0000, 0, 0, 0));
        rows.push_back(mkt(mk(ACT_SET, '1, 64'h1234, '1, '1), ST_OK, 2));
        rows.push_back(mk(ACT_GET, '1, 0, 0, '1));
        rows.push_back(mkt(mk(ACT_SET, 64'h0063_6261, 64'h55, 10, 100), ST_OK, 3));
        rows.push_back(mk(ACT_GET, 64'hAB00_0063_6261, 0, 0, 110));
        rows.push_back(mkt(mk(ACT_GET, 64'h0063_6261, 0, 0, 111), ST_MISS, 2));
        rows.push_back(mkt(mk(ACT_SET, 64'h0063_6261, 64'h66, 0, 5), ST_OK, 3));
        rows.push_back(mk(ACT_SET, 64'h0063_6261, 64'h77, 1, 5));
        rows.push_back(mkt(mk(ACT_DEL, 64'h0063_6261, 0, 0, '1), ST_OK, 2));
        // two-byte keys with equal 33*first+second share one bucket: four fill it, the fifth is full
        rows.push_back(mkt(mk(ACT_SET, 64'h6141, 64'd1, 100, 0), ST_OK, 3));
        rows.push_back(mkt(mk(ACT_SET, 64'h8240, 64'd2, 100, 0), ST_OK, 4));
        rows.push_back(mkt(mk(ACT_SET, 64'hA33F, 64'd3, 100, 0), ST_OK, 5));
        rows.push_back(mkt(mk(ACT_SET, 64'h4042, 64'd4, 100, 0), ST_OK, 6));
        rows.push_back(mkt(mk(ACT_SET, 64'h1F43, 64'd5, 100, 0), ST_FULL, 6));
        rows.push_back(mk(ACT_GET, 64'h4042, 0, 0, 50));
        rows.push_back(mkt(mk(ACT_CLEAR, '1, '1, '1, '1), ST_OK, 0));
        rows.push_back(mkt(mk(ACT_GET, '1, 0, 0, 0), ST_MISS, 0));
        rows.push_back(mkt(mk(ACT_SET, 64'h61, 64'haaaa_5555_aaaa_5555, '1, 0), ST_OK, 1));
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) begin
            send_request(rows[i]);
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        // random part: small key pool so hits and expiry happen
        k = 0;
        while (k < 700) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
                r = mk(2'($urandom_range(0, 2)), key_pool[$urandom_range(0, 15)],
                       {$urandom, $urandom}, 31'($urandom_range(0, 60)),
                       32'($urandom_range(1000, 1100)));
                case ($urandom_range(0, 9))
                    0: r.item_key = {$urandom, $urandom};
                    1: r.life_seconds = 31'($urandom);
                    2: r.now_seconds = $urandom;
                    3: r.item_key = key_pool[$urandom_range(0, 15)] | (64'hff << (8*$urandom_range(1, 7)));
                    default: ;
                endcase
                if ($urandom_range(0, 120) == 0) r.action = ACT_CLEAR;
                send_request(r);
                k++;
            end
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("** ttl_key_value_hash_table: PASSED **");
        else
            $display("** ttl_key_value_hash_table: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
